// ===== rtl/core/lbpc_pkg.sv =====
// shared types, constants and tables for the lidar beam converter
`timescale 1ns / 1ps
package lbpc_pkg;
    localparam int DEF_MAX_BEAMS     = 4096;
    localparam int DEF_CORDIC_STAGES = 16;
    localparam int MAX_STAGES        = 24;
    localparam int IDX_W             = 12;
    localparam int RNG_W             = 16;
    localparam int ANG_W             = 30;
    localparam int CW                = 36;
    localparam int ZW                = 33;
    localparam int CFG_AW            = 3;
    localparam int CFG_DW            = 24;
    localparam logic [25:0] PHASE_K  = 26'd42722830;
    localparam logic [15:0] GAIN_Q16 = 16'd39797;

    localparam logic [CFG_AW-1:0] REG_START  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_STEP   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FILT   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_RLOW   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_RHIGH  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_ALOW   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_AHIGH  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_CWMODE = 3'd7;

    // item handed from front to back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [RNG_W-1:0] rng;
        logic [ZW-1:0]    z;
        logic             neg;
    } lbpc_job_t;

    // arctangent in units of 2^-32 turn
    function automatic logic [29:0] atan_turns(input int i);
        logic [29:0] t;
        unique case (i)
            0: t = 30'd536870912;  1: t = 30'd316933406;  2: t = 30'd167458907;
            3: t = 30'd85004756;   4: t = 30'd42667331;   5: t = 30'd21354465;
            6: t = 30'd10679838;   7: t = 30'd5340245;    8: t = 30'd2670163;
            9: t = 30'd1335087;   10: t = 30'd667544;    11: t = 30'd333772;
            12: t = 30'd166886;   13: t = 30'd83443;     14: t = 30'd41722;
            15: t = 30'd20861;    16: t = 30'd10430;     17: t = 30'd5215;
            18: t = 30'd2608;     19: t = 30'd1304;      20: t = 30'd652;
            21: t = 30'd326;      22: t = 30'd163;       default: t = 30'd81;
        endcase
        return t;
    endfunction
endpackage

// ===== rtl/core/lbpc_front.sv =====
// front: beam angle, filtering and phase setup, pipelined in two stages
`timescale 1ns / 1ps
module lbpc_front import lbpc_pkg::*; #(
    parameter int MAX_BEAMS = DEF_MAX_BEAMS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [IDX_W-1:0]         in_idx,
    input  logic [RNG_W-1:0]         in_rng,
    input  logic                     advance,
    input  logic signed [23:0]       start_angle,
    input  logic signed [16:0]       angle_step,
    input  logic [1:0]               filter_enables,
    input  logic [RNG_W-1:0]         range_low,
    input  logic [RNG_W-1:0]         range_high,
    input  logic signed [23:0]       angle_low,
    input  logic signed [23:0]       angle_high,
    output logic                     out_valid,
    output lbpc_job_t                out_job
);
    // stage 1: angle
    logic                    v1_reg;
    logic [IDX_W-1:0]        i1_reg;
    logic [RNG_W-1:0]        r1_reg;
    logic signed [ANG_W-1:0] a1_reg;
    logic                    ok1;
    // stage 2: filter and phase product
    logic                    v2_reg;
    logic [IDX_W-1:0]        i2_reg;
    logic [RNG_W-1:0]        r2_reg;
    logic signed [56:0]      p2_reg;
    logic                    keep;
    logic [31:0]             ph;
    logic signed [ZW-1:0]    zs, zo;
    logic                    flip;
    logic signed [56:0]      prod;

    assign ok1 = (32'(in_idx) < 32'(MAX_BEAMS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (advance) begin
            v1_reg <= in_valid && ok1;
        end
        if (advance) begin
            i1_reg <= in_idx;
            r1_reg <= in_rng;
            a1_reg <= ANG_W'(start_angle) + ANG_W'(angle_step * $signed({1'b0, in_idx}));
        end
    end

    // range filter and filter on the unwrapped angle
    always_comb begin
        keep = v1_reg;
        if (filter_enables[0] && (r1_reg < range_low || r1_reg > range_high)) keep = 1'b0;
        if (filter_enables[1] && (a1_reg < ANG_W'(angle_low) || a1_reg > ANG_W'(angle_high)))
            keep = 1'b0;
    end

    assign prod = 57'(a1_reg) * $signed({31'd0, PHASE_K});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (advance) begin
            v2_reg <= keep;
        end
        if (advance) begin
            i2_reg <= i1_reg;
            r2_reg <= r1_reg;
            p2_reg <= prod;
        end
    end

    // fold the phase into the right half plane
    always_comb begin
        ph   = p2_reg[47:16];
        zs   = ZW'($signed(ph));
        flip = 1'b0;
        zo   = zs;
        if (zs >= $signed(ZW'(33'sd1073741824))) begin
            zo = zs - ZW'(33'sd2147483648); flip = 1'b1;
        end else if (zs < -$signed(ZW'(33'sd1073741824))) begin
            zo = zs + ZW'(33'sd2147483648); flip = 1'b1;
        end
    end

    assign out_valid   = v2_reg;
    assign out_job.idx = i2_reg;
    assign out_job.rng = r2_reg;
    assign out_job.z   = zo;
    assign out_job.neg = flip;
endmodule

// ===== rtl/core/lbpc_queue.sv =====
// short request queue between front and back
`timescale 1ns / 1ps
module lbpc_queue import lbpc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_en,
    input  lbpc_job_t wr_data,
    input  logic      rd_en,
    output logic      empty,
    output logic [2:0] count,
    output lbpc_job_t rd_data
);
    lbpc_job_t  mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 2'd1;
            if (rd_en) rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + 3'(wr_en) - 3'(rd_en);
        end
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];
    assign empty   = (cnt_reg == 3'd0);
    assign count   = cnt_reg;
endmodule

// ===== rtl/core/lbpc_back.sv =====
// back: pipelined rotation cordic, rounding, saturation and sign
`timescale 1ns / 1ps
module lbpc_back import lbpc_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  lbpc_job_t        in_job,
    input  logic             advance,
    input  logic             clockwise_mode,
    output logic             out_valid,
    output logic [16:0]      out_x,
    output logic [16:0]      out_y,
    output logic [IDX_W-1:0] out_idx
);
    localparam int N = CORDIC_STAGES;

    logic                    v_reg [N+1];
    logic signed [CW-1:0]    x_reg [N+1];
    logic signed [CW-1:0]    y_reg [N+1];
    logic signed [ZW-1:0]    z_reg [N+1];
    logic                    n_reg [N+1];
    logic [IDX_W-1:0]        i_reg [N+1];
    logic signed [CW-1:0]    xr, yr;
    logic signed [17:0]      xs, ys;

    // gain applied at entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (advance) begin
            v_reg[0] <= in_valid;
        end
        if (advance) begin
            x_reg[0] <= CW'(in_job.rng * GAIN_Q16);
            y_reg[0] <= '0;
            z_reg[0] <= in_job.z;
            n_reg[0] <= in_job.neg ^ ~clockwise_mode;
            i_reg[0] <= in_job.idx;
        end
    end

    // one micro-rotation per stage
    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic signed [ZW-1:0] T = ZW'(atan_turns(g));
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g+1] <= 1'b0;
            end else if (advance) begin
                v_reg[g+1] <= v_reg[g];
            end
            if (advance) begin
                if (!z_reg[g][ZW-1]) begin
                    x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] - T;
                end else begin
                    x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] + T;
                end
                n_reg[g+1] <= n_reg[g];
                i_reg[g+1] <= i_reg[g];
            end
        end
    end

    // round half up, saturate, sign
    always_comb begin
        xr = (x_reg[N] + CW'(32768)) >>> 16;
        yr = (y_reg[N] + CW'(32768)) >>> 16;
        if (xr > CW'(65535)) xs = 18'sd65535;
        else if (xr < -CW'(65535)) xs = -18'sd65535;
        else xs = 18'(xr);
        if (yr > CW'(65535)) ys = 18'sd65535;
        else if (yr < -CW'(65535)) ys = -18'sd65535;
        else ys = 18'(yr);
        if (n_reg[N]) begin
            xs = -xs; ys = -ys;
        end
    end

    assign out_valid = v_reg[N];
    assign out_x     = xs[16:0];
    assign out_y     = ys[16:0];
    assign out_idx   = i_reg[N];
endmodule

// ===== rtl/core/lidar_beam_polar_to_cartesian.sv =====
// Pipeline: 2 front stages, the request queue, 1 + CORDIC_STAGES back stages, one output stage.
// Throughput: one beam per clock when nothing stalls; the back pipeline with its output register sets the rate.
// The front stalls only when the queue holds two or more entries; the back stalls on m_axis_tready.
// Reset (aresetn low, synchronous) empties both pipelines and the queue and
// loads register defaults.
`timescale 1ns / 1ps
module lidar_beam_polar_to_cartesian import lbpc_pkg::*; #(
    parameter int MAX_BEAMS     = DEF_MAX_BEAMS,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // beam_index[11:0], range_value[27:12]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [47:0]       m_axis_tdata,   // x_pos[16:0], y_pos[33:17], point_index[45:34]
    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);
    logic signed [23:0] start_reg, alow_reg, ahigh_reg;
    logic signed [16:0] step_reg;
    logic [1:0]         filt_reg;
    logic [15:0]        rlow_reg, rhigh_reg;
    logic               cw_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0; step_reg <= 17'sd4573; filt_reg <= '0;
            rlow_reg <= 16'd205; rhigh_reg <= 16'd20480;
            alow_reg <= -24'sd2621440; ahigh_reg <= 24'sd2621440; cw_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_START:  start_reg <= cfg_wdata;
                REG_STEP:   step_reg  <= cfg_wdata[16:0];
                REG_FILT:   filt_reg  <= cfg_wdata[1:0];
                REG_RLOW:   rlow_reg  <= cfg_wdata[15:0];
                REG_RHIGH:  rhigh_reg <= cfg_wdata[15:0];
                REG_ALOW:   alow_reg  <= cfg_wdata;
                REG_AHIGH:  ahigh_reg <= cfg_wdata;
                REG_CWMODE: cw_reg    <= cfg_wdata[0];
            endcase
        end
    end

    logic       f_valid, q_empty, q_rd, b_adv, b_valid;
    logic [2:0] q_count;
    lbpc_job_t  f_job, q_job;
    logic [16:0] bx, by;
    logic [IDX_W-1:0] bi;
    logic       ov_reg;
    logic [47:0] od_reg;
    logic       o_load;

    // front runs while the queue has room for everything in flight
    assign s_axis_tready = (q_count <= 3'd1);

    lbpc_front #(.MAX_BEAMS(MAX_BEAMS)) u_front (
        .aclk, .aresetn,
        .in_valid(s_axis_tvalid && s_axis_tready),
        .in_idx(s_axis_tdata[11:0]), .in_rng(s_axis_tdata[27:12]),
        .advance(s_axis_tready),
        .start_angle(start_reg), .angle_step(step_reg), .filter_enables(filt_reg),
        .range_low(rlow_reg), .range_high(rhigh_reg),
        .angle_low(alow_reg), .angle_high(ahigh_reg),
        .out_valid(f_valid), .out_job(f_job)
    );

    lbpc_queue u_queue (
        .aclk, .aresetn,
        .wr_en(f_valid && s_axis_tready), .wr_data(f_job),
        .rd_en(q_rd), .empty(q_empty), .count(q_count), .rd_data(q_job)
    );

    // back pipeline advances whenever the output register can take its result or its last stage is empty
    assign o_load = !ov_reg || m_axis_tready;
    assign b_adv  = o_load || !b_valid;
    assign q_rd   = b_adv && !q_empty;

    lbpc_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .aclk, .aresetn,
        .in_valid(!q_empty), .in_job(q_job), .advance(b_adv),
        .clockwise_mode(cw_reg),
        .out_valid(b_valid), .out_x(bx), .out_y(by), .out_idx(bi)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (o_load) begin
            ov_reg <= b_valid;
        end
        if (o_load && b_valid) od_reg <= {2'b00, bi, by, bx};
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
endmodule

// ===== rtl/core/lbpc_checker.sv =====
// port-level checks for the lidar beam converter, bound to the top level
`timescale 1ns / 1ps
module lbpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // pad bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[47:46] == 2'b00)
        else $error("pad bits set");
    // no result in the cycle after a reset cycle
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result after reset");
    // x never reaches the negative extreme
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[16:0] != 17'h10000)
        else $error("x out of range");
endmodule

bind lidar_beam_polar_to_cartesian lbpc_checker u_lbpc_checker (.*);
